@@ hw/rtl/papt_pkg.sv @@
// Shared types and constants for the patch adjacency perimeter table.
package papt_pkg;

    localparam int MAX_ADJ = 64;
    localparam int ADDR_W  = $clog2(MAX_ADJ);
    localparam int CNT_W   = $clog2(MAX_ADJ + 1);

    localparam int COORD_W = 12;
    localparam int GRID_W  = 13;
    localparam int WORD_W  = 32;
    localparam int OFS_W   = 2;
    localparam int CFG_IDX_W = 2;

    // neighbour coordinate with a sign bit
    localparam int NB_W    = GRID_W + 1;

    localparam logic [GRID_W-1:0] GRID_DIM_MAX = GRID_W'(4096);

    // Q16.16 steps
    localparam logic [WORD_W-1:0] STEP_EDGE = 32'd65536;
    localparam logic [WORD_W-1:0] STEP_DIAG = 32'd46341;

    localparam logic signed [OFS_W-1:0] OFFSET_BAD = 2'sb10;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_PATCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_NEIGH = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        RES_ZERO   = 3'd0,
        RES_READ   = 3'd1,
        RES_HIT    = 3'd2,
        RES_APPEND = 3'd3,
        RES_FULL   = 3'd4
    } res_kind_t;

    typedef struct packed {
        logic      cap;
        logic      clear_cnt;
        logic      scan_start;
        logic      scan_step;
        logic      rd_sel_index;
        logic      res_load;
        res_kind_t res_kind;
        logic      wr_en;
        logic      out_push;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic pass;
        logic match;
        logic miss;
        logic full;
        logic out_free;
    } ctrl_status_t;

endpackage

@@ hw/rtl/papt_ctrl.sv @@
// Sequencing state machine: decode, table scan, result hand-off.
module papt_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  papt_pkg::ctrl_status_t status,
    output papt_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_READ   = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = papt_pkg::RES_ZERO;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.op)
                    papt_pkg::OP_CLEAR:
                    begin
                        cmd.clear_cnt = 1'b1;
                        cmd.res_load  = 1'b1;
                        state_next    = ST_OUT;
                    end
                    papt_pkg::OP_READ:
                    begin
                        cmd.rd_sel_index = 1'b1;
                        state_next       = ST_READ;
                    end
                    papt_pkg::OP_NEIGH:
                    begin
                        if (status.pass)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        else
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_OUT;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = ST_OUT;
                    end
                endcase
            end
            ST_READ:
            begin
                cmd.res_load = 1'b1;
                cmd.res_kind = papt_pkg::RES_READ;
                state_next   = ST_OUT;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.match)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = papt_pkg::RES_HIT;
                    cmd.wr_en    = 1'b1;
                    state_next   = ST_OUT;
                end
                else if (status.miss)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_OUT;
                    if (status.full)
                    begin
                        cmd.res_kind = papt_pkg::RES_FULL;
                    end
                    else
                    begin
                        cmd.res_kind = papt_pkg::RES_APPEND;
                        cmd.wr_en    = 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_push = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/papt_datapath.sv @@
// Item registers, config registers, entry memories, scan pointer and output register.
module papt_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [papt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [papt_pkg::WORD_W-1:0]           cfg_wdata,
    input  logic [1:0]                            in_op,
    input  logic [papt_pkg::COORD_W-1:0]          in_row,
    input  logic [papt_pkg::COORD_W-1:0]          in_col,
    input  logic signed [papt_pkg::OFS_W-1:0]     in_orow,
    input  logic signed [papt_pkg::OFS_W-1:0]     in_ocol,
    input  logic signed [papt_pkg::WORD_W-1:0]    in_patch,
    input  logic signed [papt_pkg::WORD_W-1:0]    in_stream,
    input  logic [papt_pkg::ADDR_W-1:0]           in_rindex,
    input  papt_pkg::ctrl_cmd_t                   cmd,
    output papt_pkg::ctrl_status_t                status,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [papt_pkg::ADDR_W-1:0]           entry_index,
    output logic                                  counted,
    output logic                                  new_entry,
    output logic                                  list_full,
    output logic signed [papt_pkg::WORD_W-1:0]    entry_patch,
    output logic [papt_pkg::WORD_W-1:0]           entry_perimeter,
    output logic [papt_pkg::CNT_W-1:0]            entry_total
);

    // config
    logic signed [papt_pkg::WORD_W-1:0] own_patch_reg;
    logic [papt_pkg::GRID_W-1:0]        grid_rows_reg;
    logic [papt_pkg::GRID_W-1:0]        grid_cols_reg;

    // captured item
    logic [1:0]                         op_reg;
    logic [papt_pkg::COORD_W-1:0]       row_reg;
    logic [papt_pkg::COORD_W-1:0]       col_reg;
    logic signed [papt_pkg::OFS_W-1:0]  orow_reg;
    logic signed [papt_pkg::OFS_W-1:0]  ocol_reg;
    logic signed [papt_pkg::WORD_W-1:0] patch_reg;
    logic signed [papt_pkg::WORD_W-1:0] stream_reg;
    logic [papt_pkg::ADDR_W-1:0]        rindex_reg;

    // table state
    logic [papt_pkg::CNT_W-1:0]  count_reg;
    logic [papt_pkg::CNT_W-1:0]  ptr_reg;
    logic                        pend_reg;
    logic [papt_pkg::ADDR_W-1:0] pend_idx_reg;

    logic [papt_pkg::WORD_W-1:0] ids_mem [papt_pkg::MAX_ADJ];
    logic [papt_pkg::WORD_W-1:0] pers_mem [papt_pkg::MAX_ADJ];
    logic [papt_pkg::WORD_W-1:0] id_q_reg;
    logic [papt_pkg::WORD_W-1:0] per_q_reg;

    // result staging
    logic [papt_pkg::ADDR_W-1:0]        res_idx_reg;
    logic                               res_counted_reg;
    logic                               res_new_reg;
    logic                               res_full_reg;
    logic signed [papt_pkg::WORD_W-1:0] res_patch_reg;
    logic [papt_pkg::WORD_W-1:0]        res_per_reg;

    logic                               out_valid_reg;
    logic [papt_pkg::ADDR_W-1:0]        out_idx_reg;
    logic                               out_counted_reg;
    logic                               out_new_reg;
    logic                               out_full_reg;
    logic signed [papt_pkg::WORD_W-1:0] out_patch_reg;
    logic [papt_pkg::WORD_W-1:0]        out_per_reg;
    logic [papt_pkg::CNT_W-1:0]         out_total_reg;

    logic signed [papt_pkg::NB_W-1:0] nb_row;
    logic signed [papt_pkg::NB_W-1:0] nb_col;
    logic                        in_grid;
    logic                        is_edge;
    logic [papt_pkg::WORD_W-1:0] step;
    logic [papt_pkg::WORD_W:0]   sum;
    logic [papt_pkg::WORD_W-1:0] per_sat;
    logic                        match;
    logic                        issue;
    logic                        read_in_range;
    logic [papt_pkg::ADDR_W-1:0] rd_addr;
    logic [papt_pkg::ADDR_W-1:0] wr_addr;
    logic [papt_pkg::WORD_W-1:0] wr_per;
    logic                        out_free;

    // neighbour tests
    always_comb
    begin
        nb_row  = $signed({2'b00, row_reg}) + papt_pkg::NB_W'(orow_reg);
        nb_col  = $signed({2'b00, col_reg}) + papt_pkg::NB_W'(ocol_reg);
        in_grid = !nb_row[papt_pkg::NB_W-1] &&
                  (nb_row[papt_pkg::NB_W-2:0] < grid_rows_reg) &&
                  !nb_col[papt_pkg::NB_W-1] &&
                  (nb_col[papt_pkg::NB_W-2:0] < grid_cols_reg);
        is_edge = (orow_reg != '0) ^ (ocol_reg != '0);
        step    = is_edge ? papt_pkg::STEP_EDGE : papt_pkg::STEP_DIAG;
        sum     = {1'b0, per_q_reg} + {1'b0, step};
        per_sat = sum[papt_pkg::WORD_W] ? '1 : sum[papt_pkg::WORD_W-1:0];
    end

    assign match    = pend_reg && (id_q_reg == patch_reg);
    assign issue    = cmd.scan_step && !match && (ptr_reg < count_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign read_in_range = ({1'b0, rindex_reg} < papt_pkg::CNT_W'(papt_pkg::MAX_ADJ));

    assign rd_addr = cmd.rd_sel_index ? rindex_reg : ptr_reg[papt_pkg::ADDR_W-1:0];
    assign wr_addr = (cmd.res_kind == papt_pkg::RES_HIT) ? pend_idx_reg
                                                         : count_reg[papt_pkg::ADDR_W-1:0];
    assign wr_per  = (cmd.res_kind == papt_pkg::RES_HIT) ? per_sat : step;

    always_comb
    begin
        status.op       = papt_pkg::op_t'(op_reg);
        status.pass     = (orow_reg != papt_pkg::OFFSET_BAD) &&
                          (ocol_reg != papt_pkg::OFFSET_BAD) && in_grid &&
                          (patch_reg != own_patch_reg) && (patch_reg > 0) &&
                          (stream_reg > 0);
        status.match    = match;
        status.miss     = !match && (ptr_reg == count_reg);
        status.full     = (count_reg == papt_pkg::CNT_W'(papt_pkg::MAX_ADJ));
        status.out_free = out_free;
    end

    // entry memories, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            ids_mem[wr_addr]  <= patch_reg;
            pers_mem[wr_addr] <= wr_per;
        end
        id_q_reg  <= ids_mem[rd_addr];
        per_q_reg <= pers_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_patch_reg <= '0;
            grid_rows_reg <= papt_pkg::GRID_DIM_MAX;
            grid_cols_reg <= papt_pkg::GRID_DIM_MAX;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    papt_pkg::CFG_OWN_PATCH: own_patch_reg <= cfg_wdata;
                    papt_pkg::CFG_GRID_ROWS: grid_rows_reg <= cfg_wdata[papt_pkg::GRID_W-1:0];
                    papt_pkg::CFG_GRID_COLS: grid_cols_reg <= cfg_wdata[papt_pkg::GRID_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.clear_cnt)
            begin
                count_reg <= '0;
            end
            else if (cmd.res_load && (cmd.res_kind == papt_pkg::RES_APPEND))
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.scan_start)
            begin
                ptr_reg <= '0;
            end
            else if (issue)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            pend_reg <= issue;

            if (cmd.out_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_reg     <= in_op;
            row_reg    <= in_row;
            col_reg    <= in_col;
            orow_reg   <= in_orow;
            ocol_reg   <= in_ocol;
            patch_reg  <= in_patch;
            stream_reg <= in_stream;
            rindex_reg <= in_rindex;
        end

        if (issue)
        begin
            pend_idx_reg <= ptr_reg[papt_pkg::ADDR_W-1:0];
        end

        if (cmd.res_load)
        begin
            case (cmd.res_kind)
                papt_pkg::RES_READ:
                begin
                    res_idx_reg     <= rindex_reg;
                    res_counted_reg <= 1'b0;
                    res_new_reg     <= 1'b0;
                    res_full_reg    <= 1'b0;
                    res_patch_reg   <= read_in_range ? id_q_reg : '0;
                    res_per_reg     <= read_in_range ? per_q_reg : '0;
                end
                papt_pkg::RES_HIT:
                begin
                    res_idx_reg     <= pend_idx_reg;
                    res_counted_reg <= 1'b1;
                    res_new_reg     <= 1'b0;
                    res_full_reg    <= 1'b0;
                    res_patch_reg   <= patch_reg;
                    res_per_reg     <= per_sat;
                end
                papt_pkg::RES_APPEND:
                begin
                    res_idx_reg     <= count_reg[papt_pkg::ADDR_W-1:0];
                    res_counted_reg <= 1'b1;
                    res_new_reg     <= 1'b1;
                    res_full_reg    <= 1'b0;
                    res_patch_reg   <= patch_reg;
                    res_per_reg     <= step;
                end
                papt_pkg::RES_FULL:
                begin
                    res_idx_reg     <= '0;
                    res_counted_reg <= 1'b0;
                    res_new_reg     <= 1'b0;
                    res_full_reg    <= 1'b1;
                    res_patch_reg   <= '0;
                    res_per_reg     <= '0;
                end
                default:
                begin
                    res_idx_reg     <= '0;
                    res_counted_reg <= 1'b0;
                    res_new_reg     <= 1'b0;
                    res_full_reg    <= 1'b0;
                    res_patch_reg   <= '0;
                    res_per_reg     <= '0;
                end
            endcase
        end

        if (cmd.out_push)
        begin
            out_idx_reg     <= res_idx_reg;
            out_counted_reg <= res_counted_reg;
            out_new_reg     <= res_new_reg;
            out_full_reg    <= res_full_reg;
            out_patch_reg   <= res_patch_reg;
            out_per_reg     <= res_per_reg;
            out_total_reg   <= count_reg;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign entry_index     = out_idx_reg;
    assign counted         = out_counted_reg;
    assign new_entry       = out_new_reg;
    assign list_full       = out_full_reg;
    assign entry_patch     = out_patch_reg;
    assign entry_perimeter = out_per_reg;
    assign entry_total     = out_total_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= papt_pkg::CNT_W'(papt_pkg::MAX_ADJ))
        else $error("entry count above table depth");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> ptr_reg <= count_reg)
        else $error("scan pointer past entry count");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && cmd.res_kind == papt_pkg::RES_APPEND)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not grow the table");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_push |-> (!out_valid_reg || m_tready))
        else $error("result pushed over a pending transfer");

endmodule

@@ hw/rtl/patch_adjacency_perimeter_table_unit.sv @@
// Top level of the patch adjacency perimeter table: stream ports and field packing.
//
// Keeps up to 64 neighbouring patch ids, each with a Q16.16 shared-edge perimeter
// that saturates at all ones. One input transfer gives exactly one result transfer.
// A clear (op 0), an ignored neighbour or an unused op goes from decode straight
// to the output state; a read (op 2) passes through a read state first. A
// neighbour that passes the tests scans the table until it matches an entry or
// reaches the end of the n entries (at most 64): the id memory's single read
// port is scanned one entry per cycle. A finished result sits in the output
// register while the next item is accepted. Config is written through cfg_we.
module patch_adjacency_perimeter_table_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // center_row[11:0], center_col[23:12], offset_row[25:24], offset_col[27:26],
    // neigh_patch[59:28], neigh_stream[91:60], read_index[97:92], zero[103:98]
    input  logic [103:0] s_tdata,
    // op[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_index[5:0], counted[6], new_entry[7], list_full[8], entry_patch[40:9],
    // entry_perimeter[72:41], entry_total[79:73]
    output logic [79:0]  m_tdata
);

    papt_pkg::ctrl_cmd_t    cmd;
    papt_pkg::ctrl_status_t status;

    logic [papt_pkg::ADDR_W-1:0]        entry_index;
    logic                               counted;
    logic                               new_entry;
    logic                               list_full;
    logic signed [papt_pkg::WORD_W-1:0] entry_patch;
    logic [papt_pkg::WORD_W-1:0]        entry_perimeter;
    logic [papt_pkg::CNT_W-1:0]         entry_total;

    papt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    papt_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_op           (s_tuser),
        .in_row          (s_tdata[11:0]),
        .in_col          (s_tdata[23:12]),
        .in_orow         (s_tdata[25:24]),
        .in_ocol         (s_tdata[27:26]),
        .in_patch        (s_tdata[59:28]),
        .in_stream       (s_tdata[91:60]),
        .in_rindex       (s_tdata[97:92]),
        .cmd             (cmd),
        .status          (status),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .entry_index     (entry_index),
        .counted         (counted),
        .new_entry       (new_entry),
        .list_full       (list_full),
        .entry_patch     (entry_patch),
        .entry_perimeter (entry_perimeter),
        .entry_total     (entry_total)
    );

    assign m_tdata = {entry_total, entry_perimeter, entry_patch,
                      list_full, new_entry, counted, entry_index};

endmodule
